### rtl/bcc_pkg.sv
package bcc_pkg;

    localparam int unsigned DEBOUNCE_RESET_US   = 20 * 1000;
    localparam int unsigned LONG_PRESS_RESET_US = 250 * 1000;
    localparam int unsigned GAP_RESET_US        = 300 * 1000;
    localparam logic [1:0]  CLICK_MAX           = 2'd3;
    localparam int unsigned QUEUE_DEPTH         = 4;

    typedef enum logic [1:0] {
        MODE_IDLE     = 2'd0,
        MODE_DEBOUNCE = 2'd1,
        MODE_PRESSED  = 2'd2,
        MODE_LONG     = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        EV_CLICK      = 3'd0,
        EV_DOUBLE     = 3'd1,
        EV_TRIPLE     = 3'd2,
        EV_PRESS_DOWN = 3'd3,
        EV_RELEASE    = 3'd4
    } t_event;

    typedef enum logic [1:0] {
        CFG_DEBOUNCE   = 2'd0,
        CFG_LONG_PRESS = 2'd1,
        CFG_GAP        = 2'd2
    } t_cfg_index;

    // Events caused by one poll: the first one always, the second when has_second is set.
    typedef struct packed {
        logic   has_second;
        t_event first;
        t_event second;
    } t_job;

    // Queue status seen by the front and the back.
    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

    function automatic t_event click_event(input logic [1:0] count);
        logic [1:0] code;
        code = count - 2'd1;
        return t_event'({1'b0, code});
    endfunction

endpackage

### rtl/bcc_front.sv
module bcc_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic                i_pin_level,
    input  logic [31:0]         i_time_us,
    input  logic                i_cfg_valid,
    input  logic [1:0]          i_cfg_index,
    input  logic [31:0]         i_cfg_data,
    input  bcc_pkg::t_queue_status i_q_status,
    output logic                o_stall,
    output logic                o_push,
    output bcc_pkg::t_job       o_job
);

    bcc_pkg::t_mode r_mode, n_mode;
    logic [31:0]    r_time, n_time;
    logic [1:0]     r_count, n_count;
    logic [31:0]    r_debounce, r_long_press, r_gap;
    logic [31:0]    elapsed;
    logic           accept;
    logic           push;
    bcc_pkg::t_job  job;

    assign o_stall = i_q_status.full;
    assign accept  = i_valid && !i_q_status.full;
    assign elapsed = i_time_us - r_time;
    assign o_push  = accept && push;
    assign o_job   = job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce   <= 32'(bcc_pkg::DEBOUNCE_RESET_US);
            r_long_press <= 32'(bcc_pkg::LONG_PRESS_RESET_US);
            r_gap        <= 32'(bcc_pkg::GAP_RESET_US);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                bcc_pkg::CFG_DEBOUNCE:   r_debounce   <= i_cfg_data;
                bcc_pkg::CFG_LONG_PRESS: r_long_press <= i_cfg_data;
                bcc_pkg::CFG_GAP:        r_gap        <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= bcc_pkg::MODE_IDLE;
            r_time  <= '0;
            r_count <= '0;
        end else if (accept) begin
            r_mode  <= n_mode;
            r_time  <= n_time;
            r_count <= n_count;
        end
    end

    always_comb begin
        n_mode         = r_mode;
        n_time         = r_time;
        n_count        = r_count;
        push           = 1'b0;
        job.has_second = 1'b0;
        job.first      = bcc_pkg::EV_PRESS_DOWN;
        job.second     = bcc_pkg::EV_PRESS_DOWN;
        unique case (r_mode)
            bcc_pkg::MODE_IDLE: begin
                if (r_count != 2'd0 && elapsed > r_gap) begin
                    push      = 1'b1;
                    job.first = bcc_pkg::click_event(r_count);
                    n_count   = 2'd0;
                end
                // A press in the same poll still starts debouncing.
                if (!i_pin_level) begin
                    n_time = i_time_us;
                    n_mode = bcc_pkg::MODE_DEBOUNCE;
                end
            end
            bcc_pkg::MODE_DEBOUNCE: begin
                if (i_pin_level) begin
                    n_time = i_time_us;
                    n_mode = bcc_pkg::MODE_IDLE;
                end else if (elapsed > r_debounce) begin
                    n_time = i_time_us;
                    n_mode = bcc_pkg::MODE_PRESSED;
                end
            end
            bcc_pkg::MODE_PRESSED: begin
                if (i_pin_level) begin
                    if (r_count < bcc_pkg::CLICK_MAX) begin
                        n_count = r_count + 2'd1;
                    end
                    n_time = i_time_us;
                    n_mode = bcc_pkg::MODE_IDLE;
                end else if (elapsed > r_long_press) begin
                    // A pending click sequence is flushed ahead of the press-down.
                    push = 1'b1;
                    if (r_count != 2'd0) begin
                        job.has_second = 1'b1;
                        job.first      = bcc_pkg::click_event(r_count);
                    end
                    n_count = 2'd0;
                    n_time  = i_time_us;
                    n_mode  = bcc_pkg::MODE_LONG;
                end
            end
            bcc_pkg::MODE_LONG: begin
                if (i_pin_level) begin
                    push      = 1'b1;
                    job.first = bcc_pkg::EV_RELEASE;
                    n_time    = i_time_us;
                    n_mode    = bcc_pkg::MODE_IDLE;
                end
            end
            default: ;
        endcase
    end

endmodule

### rtl/bcc_queue.sv
module bcc_queue #(
    parameter int unsigned DEPTH = bcc_pkg::QUEUE_DEPTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  bcc_pkg::t_job          i_job,
    input  logic                   i_pop,
    output bcc_pkg::t_job          o_job,
    output bcc_pkg::t_queue_status o_status
);

    // DEPTH must be at least two.
    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);

    bcc_pkg::t_job r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          do_push, do_pop;

    assign o_status.full  = (r_count == CW'(DEPTH));
    assign o_status.empty = (r_count == '0);
    assign do_push = i_push && !o_status.full;
    assign do_pop  = i_pop && !o_status.empty;
    assign o_job   = r_mem[r_rd_ptr];

    function automatic logic [AW-1:0] next_ptr(input logic [AW-1:0] ptr);
        return (ptr == AW'(DEPTH - 1)) ? '0 : ptr + AW'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= next_ptr(r_wr_ptr);
            end
            if (do_pop) begin
                r_rd_ptr <= next_ptr(r_rd_ptr);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

### rtl/bcc_back.sv
module bcc_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  bcc_pkg::t_job          i_job,
    input  bcc_pkg::t_queue_status i_q_status,
    input  logic                   i_stall,
    output logic                   o_pop,
    output logic                   o_valid,
    output logic [2:0]             o_event_code,
    output logic                   o_last_of_run
);

    logic            r_valid, n_valid;
    bcc_pkg::t_event r_code, n_code;
    logic            r_last, n_last;
    logic            r_pend, n_pend;
    bcc_pkg::t_event r_pend_code, n_pend_code;
    logic            slot_free;

    assign slot_free     = !r_valid || !i_stall;
    assign o_valid       = r_valid;
    assign o_event_code  = r_code;
    assign o_last_of_run = r_last;

    always_comb begin
        n_valid     = r_valid;
        n_code      = r_code;
        n_last      = r_last;
        n_pend      = r_pend;
        n_pend_code = r_pend_code;
        o_pop       = 1'b0;
        if (slot_free) begin
            priority if (r_pend) begin
                n_valid = 1'b1;
                n_code  = r_pend_code;
                n_last  = 1'b1;
                n_pend  = 1'b0;
            end else if (!i_q_status.empty) begin
                o_pop       = 1'b1;
                n_valid     = 1'b1;
                n_code      = i_job.first;
                n_last      = !i_job.has_second;
                n_pend      = i_job.has_second;
                n_pend_code = i_job.second;
            end else begin
                n_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pend  <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_code      <= n_code;
        r_last      <= n_last;
        r_pend_code <= n_pend_code;
    end

endmodule

### rtl/button_click_classifier.sv
// A poll's events enter the job queue when it is accepted and reach o_valid via the back end's
// output register. Throughput: one poll per cycle unless o_stall; events leave one per cycle
// unless i_stall. Jobs wait in a small job queue; o_stall rises only when it is full.
// Reset (synchronous, active low): mode idle, click count and timestamp zero, thresholds back
// to their defaults, queue and output register empty.
module button_click_classifier #(
    parameter int unsigned QUEUE_DEPTH = bcc_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_pin_level,
    input  logic [31:0] i_time_us,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_event_code,
    output logic        o_last_of_run,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    bcc_pkg::t_job          push_job, head_job;
    bcc_pkg::t_queue_status q_status;
    logic                   push, pop;
    logic                   cfg_write;

    assign o_cfg_ready = 1'b1;
    assign cfg_write   = i_cfg_valid && o_cfg_ready;

    bcc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_pin_level (i_pin_level),
        .i_time_us   (i_time_us),
        .i_cfg_valid (cfg_write),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_q_status  (q_status),
        .o_stall     (o_stall),
        .o_push      (push),
        .o_job       (push_job)
    );

    bcc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_job    (push_job),
        .i_pop    (pop),
        .o_job    (head_job),
        .o_status (q_status)
    );

    bcc_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_job         (head_job),
        .i_q_status    (q_status),
        .i_stall       (i_stall),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .o_event_code  (o_event_code),
        .o_last_of_run (o_last_of_run)
    );

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(push && q_status.full))
        else $error("job pushed into a full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(pop && q_status.empty))
        else $error("job popped from an empty queue");

    // The only two-event run is a flushed click sequence followed by press-down.
    a_first_is_click: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last_of_run) |->
        (o_event_code == bcc_pkg::EV_CLICK || o_event_code == bcc_pkg::EV_DOUBLE ||
         o_event_code == bcc_pkg::EV_TRIPLE))
        else $error("non-final beat is not a click event");

    a_press_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && !o_last_of_run) |=>
        (o_valid && o_last_of_run && o_event_code == bcc_pkg::EV_PRESS_DOWN))
        else $error("flushed click not followed by press-down");

endmodule

### verif/button_click_classifier_tb.sv
module button_click_classifier_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Index three names no register; writes to it must leave the thresholds alone.
    localparam logic [1:0] CFG_RESERVED   = 2'd3;
    localparam int         DRAIN_CYCLES   = 12;
    localparam int         WATCHDOG_LIMIT = 2000;
    localparam logic [31:0] ALL_ONES      = 32'hFFFF_FFFF;

    typedef struct packed {
        logic        pin;
        logic [31:0] stamp;
    } t_poll;

    typedef struct packed {
        bcc_pkg::t_event code;
        logic            last;
    } t_click_report;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic        i_pin_level;
    logic [31:0] i_time_us;
    logic        o_valid;
    logic        i_stall;
    logic [2:0]  o_event_code;
    logic        o_last_of_run;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [31:0] i_cfg_data;

    t_poll         poll_queue[$];
    t_click_report expected_events[$];

    // Threshold mirror and button state of the predictor.
    logic [31:0]    deb_us  = bcc_pkg::DEBOUNCE_RESET_US;
    logic [31:0]    long_us = bcc_pkg::LONG_PRESS_RESET_US;
    logic [31:0]    gap_us  = bcc_pkg::GAP_RESET_US;
    bcc_pkg::t_mode btn_mode = bcc_pkg::MODE_IDLE;
    logic [31:0]    stamp_us = 32'd0;
    logic [1:0]     clicks   = 2'd0;

    logic [31:0] now_us = 32'd0;
    int          polls_queued = 0;
    int          polls_seen   = 0;
    int          events_seen  = 0;
    int          cfg_writes   = 0;
    int          fail_count   = 0;
    int          idle_cycles  = 0;
    logic        poll_taken   = 1'b0;
    bit          quiet_run    = 1'b0;

    int          send_gap     = 0;
    bit          send_jitter  = 1'b1;
    int          stall_left   = 0;
    bit          stall_jitter = 1'b1;

    button_click_classifier i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_pin_level   (i_pin_level),
        .i_time_us     (i_time_us),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_event_code  (o_event_code),
        .o_last_of_run (o_last_of_run),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // A new event always closes the run; when chained, the one before it loses its last flag.
    function automatic void add_event(input bcc_pkg::t_event code, input logic chained);
        if (chained) begin
            expected_events[expected_events.size() - 1].last = 1'b0;
        end
        expected_events.push_back('{code: code, last: 1'b1});
    endfunction

    function automatic void classify_poll(input logic pin, input logic [31:0] now);
        logic [31:0] elapsed;
        logic        chained;
        elapsed = now - stamp_us;
        chained = 1'b0;
        case (btn_mode)
            bcc_pkg::MODE_IDLE: begin
                if (clicks != 2'd0 && elapsed > gap_us) begin
                    add_event(bcc_pkg::t_event'({1'b0, clicks - 2'd1}), chained);
                    clicks = 2'd0;
                end
                if (!pin) begin
                    stamp_us = now;
                    btn_mode = bcc_pkg::MODE_DEBOUNCE;
                end
            end
            bcc_pkg::MODE_DEBOUNCE: begin
                if (pin) begin
                    stamp_us = now;
                    btn_mode = bcc_pkg::MODE_IDLE;
                end else if (elapsed > deb_us) begin
                    stamp_us = now;
                    btn_mode = bcc_pkg::MODE_PRESSED;
                end
            end
            bcc_pkg::MODE_PRESSED: begin
                if (pin) begin
                    if (clicks != bcc_pkg::CLICK_MAX) begin
                        clicks = clicks + 2'd1;
                    end
                    stamp_us = now;
                    btn_mode = bcc_pkg::MODE_IDLE;
                end else if (elapsed > long_us) begin
                    if (clicks != 2'd0) begin
                        add_event(bcc_pkg::t_event'({1'b0, clicks - 2'd1}), chained);
                        chained = 1'b1;
                        clicks = 2'd0;
                    end
                    add_event(bcc_pkg::EV_PRESS_DOWN, chained);
                    stamp_us = now;
                    btn_mode = bcc_pkg::MODE_LONG;
                end
            end
            default: begin
                if (pin) begin
                    add_event(bcc_pkg::EV_RELEASE, chained);
                    stamp_us = now;
                    btn_mode = bcc_pkg::MODE_IDLE;
                end
            end
        endcase
    endfunction

    // A delay at, just around, or anywhere below a threshold; wraps modulo 2^32.
    function automatic logic [31:0] near(input logic [31:0] th);
        logic [31:0] d;
        case ($urandom_range(0, 4))
            0: d = th;
            1: d = th + 32'd1;
            2: d = th - 32'd1;
            3: d = th + 32'd2 + $urandom_range(0, 15);
            default: d = $urandom_range(0, th);
        endcase
        return d;
    endfunction

    task automatic queue_poll(input logic pin, input logic [31:0] t);
        poll_queue.push_back('{pin: pin, stamp: t});
        now_us = t;
        polls_queued++;
    endtask

    task automatic press_episode(input logic [31:0] deb, input logic [31:0] lng,
                                 input logic [31:0] gap);
        if ($urandom_range(0, 3) == 0) begin
            queue_poll(1'b0, now_us + near(gap));
        end else begin
            queue_poll(1'b0, now_us + $urandom_range(0, 7));
        end
        if ($urandom_range(0, 7) == 0) begin
            queue_poll(1'b1, now_us + $urandom_range(0, 7));
            return;
        end
        queue_poll(1'b0, now_us + near(deb));
        if ($urandom_range(0, 2) == 0) begin
            queue_poll(1'b0, now_us + $urandom_range(0, 7));
        end
        if ($urandom_range(0, 3) == 0) begin
            queue_poll(1'b0, now_us + near(lng));
            if ($urandom_range(0, 1) == 0) begin
                queue_poll(1'b0, now_us + $urandom_range(0, 7));
            end
        end
        queue_poll(1'b1, now_us + $urandom_range(0, 7));
        if ($urandom_range(0, 1) == 0) begin
            queue_poll(1'b1, now_us + near(gap));
        end
    endtask

    task automatic noise_burst(input logic [31:0] gap);
        repeat ($urandom_range(1, 4)) begin
            queue_poll(1'($urandom_range(0, 1)),
                       ($urandom_range(0, 3) == 0) ? $urandom
                                                   : now_us + $urandom_range(0, gap));
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Returns once every poll is in, every event is out, and the pipeline has had time to empty.
    task automatic drain();
        while (polls_seen != polls_queued) @(negedge i_clk);
        while (expected_events.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic run_phase(input logic [31:0] deb, input logic [31:0] lng,
                             input logic [31:0] gap, input int n_polls, input bit rebase);
        int start;
        start = polls_queued;
        write_reg(bcc_pkg::CFG_DEBOUNCE, deb);
        write_reg(bcc_pkg::CFG_LONG_PRESS, lng);
        write_reg(bcc_pkg::CFG_GAP, gap);
        if ($urandom_range(0, 2) == 0) begin
            write_reg(CFG_RESERVED, $urandom);
        end
        if (rebase) begin
            now_us = $urandom;
        end
        while (polls_queued - start < n_polls) begin
            if ($urandom_range(0, 9) < 7) begin
                press_episode(deb, lng, gap);
            end else begin
                noise_burst(gap);
            end
        end
        drain();
    endtask

    always @(negedge i_clk) begin : drive_polls
        t_poll item;
        if (i_rst_n) begin
            if ($urandom_range(0, 63) == 0) begin
                send_jitter = !send_jitter;
            end
            if (i_valid && !poll_taken) begin
                // Stalled beat: hold the payload.
            end else if (send_gap > 0) begin
                send_gap--;
                i_valid <= 1'b0;
            end else if (poll_queue.size() != 0) begin
                if (!quiet_run && send_jitter && $urandom_range(0, 5) == 0) begin
                    send_gap = $urandom_range(0, 7);
                    i_valid <= 1'b0;
                end else begin
                    item = poll_queue.pop_front();
                    i_valid     <= 1'b1;
                    i_pin_level <= item.pin;
                    i_time_us   <= item.stamp;
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin : pace_results
        if (quiet_run) begin
            stall_left = 0;
            i_stall <= 1'b0;
        end else begin
            if ($urandom_range(0, 49) == 0) begin
                stall_jitter = !stall_jitter;
            end
            if (stall_left > 0) begin
                stall_left--;
                i_stall <= 1'b1;
            end else if (stall_jitter && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(0, 7);
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin : check_events
        t_click_report want;
        logic          moved;
        if (i_rst_n) begin
            moved = 1'b0;
            poll_taken <= i_valid && !o_stall;
            if (o_valid && !i_stall) begin
                moved = 1'b1;
                events_seen++;
                if (expected_events.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected event: expected none, actual code %0d last %0b",
                             $time, o_event_code, o_last_of_run);
                end else begin
                    want = expected_events.pop_front();
                    if (o_event_code !== want.code) begin
                        fail_count++;
                        $display("%0t: event code: expected %0d, actual %0d",
                                 $time, want.code, o_event_code);
                    end
                    if (o_last_of_run !== want.last) begin
                        fail_count++;
                        $display("%0t: last_of_run: expected %0b, actual %0b",
                                 $time, want.last, o_last_of_run);
                    end
                end
            end
            if (i_valid && !o_stall) begin
                moved = 1'b1;
                polls_seen++;
                classify_poll(i_pin_level, i_time_us);
            end
            if (i_cfg_valid && o_cfg_ready) begin
                moved = 1'b1;
                cfg_writes++;
                case (i_cfg_index)
                    bcc_pkg::CFG_DEBOUNCE:   deb_us  = i_cfg_data;
                    bcc_pkg::CFG_LONG_PRESS: long_us = i_cfg_data;
                    bcc_pkg::CFG_GAP:        gap_us  = i_cfg_data;
                    default: ;
                endcase
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("button_click_classifier: mismatch");
                $finish;
            end
        end
    end

    initial begin : stimulus
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_pin_level = 1'b1;
        i_time_us   = 32'd0;
        i_stall     = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = bcc_pkg::CFG_DEBOUNCE;
        i_cfg_data  = 32'd0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Default thresholds: bounce, debounce edge, saturation at three clicks, expiry
        // together with a new press, flush before press-down, release, and timestamp wrap.
        queue_poll(1'b1, 32'd0);
        queue_poll(1'b0, 32'd1000);
        queue_poll(1'b1, 32'd5000);
        queue_poll(1'b0, 32'd6000);
        queue_poll(1'b0, 32'd26000);
        queue_poll(1'b0, 32'd26001);
        queue_poll(1'b1, 32'd30000);
        queue_poll(1'b0, 32'd40000);
        queue_poll(1'b0, 32'd60001);
        queue_poll(1'b1, 32'd61000);
        queue_poll(1'b0, 32'd70000);
        queue_poll(1'b0, 32'd90001);
        queue_poll(1'b1, 32'd91000);
        queue_poll(1'b0, 32'd100000);
        queue_poll(1'b0, 32'd120001);
        queue_poll(1'b1, 32'd121000);
        queue_poll(1'b0, 32'd421001);
        queue_poll(1'b0, 32'd441002);
        queue_poll(1'b1, 32'd442000);
        queue_poll(1'b0, 32'd450000);
        queue_poll(1'b0, 32'd470001);
        queue_poll(1'b0, 32'd720002);
        queue_poll(1'b1, 32'd730000);
        queue_poll(1'b0, ALL_ONES - 32'd15);
        queue_poll(1'b0, 32'd19985);
        queue_poll(1'b1, 32'd20000);
        queue_poll(1'b1, 32'd10);
        drain();

        run_phase(32'd20, 32'd250, 32'd300, 200, 1'b0);
        run_phase(32'd0, 32'd0, 32'd0, 150, 1'b1);
        run_phase(ALL_ONES, ALL_ONES, ALL_ONES, 100, 1'b1);
        run_phase($urandom_range(0, 40), $urandom_range(0, 200), $urandom_range(0, 200),
                  250, 1'b1);
        run_phase(bcc_pkg::DEBOUNCE_RESET_US, bcc_pkg::LONG_PRESS_RESET_US,
                  bcc_pkg::GAP_RESET_US, 200, 1'b1);
        run_phase($urandom, $urandom, $urandom, 150, 1'b1);
        quiet_run = 1'b1;
        run_phase($urandom_range(1, 30), $urandom_range(30, 300), $urandom_range(0, 300),
                  300, 1'b1);

        $display("Covered %0d polls and %0d events over %0d register writes,", polls_seen,
                 events_seen, cfg_writes);
        $display("with thresholds from zero to all ones and timestamps wrapping around.");
        if (fail_count == 0 && expected_events.size() == 0) begin
            $display("button_click_classifier: match");
        end else begin
            $display("button_click_classifier: mismatch");
        end
        $finish;
    end

endmodule

### sim.f
rtl/bcc_pkg.sv
rtl/bcc_front.sv
rtl/bcc_queue.sv
rtl/bcc_back.sv
rtl/button_click_classifier.sv
verif/button_click_classifier_tb.sv
